// ===== rtl/dss_pkg.sv =====
// ============================================================================
// dss_pkg
// Shared types and constants for the dual stack shared store block.
// ============================================================================
`default_nettype none

package dss_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int CNT_W         = 9;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 8;
    localparam int CMD_W         = 3;
    localparam int STAT_W        = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SEARCH = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_MISS  = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/dss_ram.sv =====
// ============================================================================
// dss_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/dss_seq.sv =====
// ============================================================================
// dss_seq
// Command sequencer: stack pointers, store access, search walk and result
// register.
// ============================================================================
`default_nettype none

module dss_seq #(
    parameter int DEPTH = dss_pkg::DEPTH_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [dss_pkg::CNT_W-1:0]        cap_eff,
    input  wire logic                             cfg_clear,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dss_pkg::CMD_W-1:0]        command,
    input  wire logic                             which_stack,
    input  wire logic [dss_pkg::DATA_W-1:0]       value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [dss_pkg::STAT_W-1:0]            status,
    output logic [dss_pkg::DATA_W-1:0]            read_value,
    output logic [dss_pkg::IDX_W-1:0]             match_index,
    output logic [dss_pkg::CNT_W-1:0]             size_low_stack,
    output logic [dss_pkg::CNT_W-1:0]             size_high_stack,
    output logic                                  is_full,
    output logic                                  wr_en,
    output logic [ADDR_W-1:0]                     wr_addr,
    output logic [dss_pkg::DATA_W-1:0]            wr_data,
    output logic [ADDR_W-1:0]                     rd_addr,
    input  wire logic [dss_pkg::DATA_W-1:0]       rd_data
);

    dss_pkg::state_t state_reg, state_next;

    logic [dss_pkg::CNT_W-1:0]  low_top_reg, low_top_next;
    logic [dss_pkg::CNT_W-1:0]  high_count_reg, high_count_next;
    logic [dss_pkg::DATA_W-1:0] key_reg, key_next;
    logic                       high_sel_reg, high_sel_next;
    logic [dss_pkg::CNT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [dss_pkg::CNT_W-1:0]  rem_reg, rem_next;

    logic [dss_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [dss_pkg::DATA_W-1:0] res_value_reg, res_value_next;
    logic [dss_pkg::IDX_W-1:0]  res_midx_reg, res_midx_next;

    logic                       out_valid_reg, out_valid_next;
    logic [dss_pkg::STAT_W-1:0] out_status_reg, out_status_next;
    logic [dss_pkg::DATA_W-1:0] out_value_reg, out_value_next;
    logic [dss_pkg::IDX_W-1:0]  out_midx_reg, out_midx_next;
    logic [dss_pkg::CNT_W-1:0]  out_low_reg, out_low_next;
    logic [dss_pkg::CNT_W-1:0]  out_high_reg, out_high_next;
    logic                       out_full_reg, out_full_next;

    logic                       accept;
    logic                       out_free;
    logic [dss_pkg::CNT_W:0]    sum_now;
    logic [dss_pkg::CNT_W:0]    sum_next;
    logic                       full_now;
    logic [dss_pkg::CNT_W-1:0]  n_sel;
    logic [dss_pkg::CNT_W-1:0]  top_idx;
    logic [dss_pkg::CNT_W-1:0]  push_idx;
    logic [dss_pkg::CNT_W-1:0]  step_idx;
    logic                       fin;
    logic [dss_pkg::STAT_W-1:0] fin_status;
    logic [dss_pkg::DATA_W-1:0] fin_value;
    logic [dss_pkg::IDX_W-1:0]  fin_midx;
    logic                       load;

    assign in_stall = (state_reg != dss_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign sum_now  = {1'b0, low_top_reg} + {1'b0, high_count_reg};
    assign full_now = (sum_now >= {1'b0, cap_eff});
    assign n_sel    = which_stack ? high_count_reg : low_top_reg;

    // The high stack's top sits at cap - count; the low stack's top at count - 1.
    assign top_idx  = which_stack ? (cap_eff - high_count_reg) : (low_top_reg - 1'b1);
    assign push_idx = which_stack ? (cap_eff - 1'b1 - high_count_reg) : low_top_reg;
    assign step_idx = high_sel_reg ? (cmp_idx_reg + 1'b1) : (cmp_idx_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dss_pkg::S_IDLE;
            low_top_reg    <= '0;
            high_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_top_reg    <= low_top_next;
            high_count_reg <= high_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        high_sel_reg   <= high_sel_next;
        cmp_idx_reg    <= cmp_idx_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_midx_reg   <= res_midx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_midx_reg   <= out_midx_next;
        out_low_reg    <= out_low_next;
        out_high_reg   <= out_high_next;
        out_full_reg   <= out_full_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        low_top_next    = low_top_reg;
        high_count_next = high_count_reg;
        key_next        = key_reg;
        high_sel_next   = high_sel_reg;
        cmp_idx_next    = cmp_idx_reg;
        rem_next        = rem_reg;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(push_idx);
        wr_data         = value;
        rd_addr         = ADDR_W'(top_idx);
        fin             = 1'b0;
        fin_status      = dss_pkg::STAT_OK;
        fin_value       = '0;
        fin_midx        = '0;

        unique case (state_reg)
            dss_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command) inside
                        dss_pkg::CMD_PUSH:
                        begin
                            fin = 1'b1;
                            if (full_now)
                            begin
                                fin_status = dss_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                if (which_stack)
                                begin
                                    high_count_next = high_count_reg + 1'b1;
                                end
                                else
                                begin
                                    low_top_next = low_top_reg + 1'b1;
                                end
                            end
                        end
                        dss_pkg::CMD_POP, dss_pkg::CMD_PEEK:
                        begin
                            if (n_sel == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = dss_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = dss_pkg::S_READ;
                                if (command == dss_pkg::CMD_POP)
                                begin
                                    if (which_stack)
                                    begin
                                        high_count_next = high_count_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        low_top_next = low_top_reg - 1'b1;
                                    end
                                end
                            end
                        end
                        dss_pkg::CMD_CLEAR:
                        begin
                            fin = 1'b1;
                            if (which_stack)
                            begin
                                high_count_next = '0;
                            end
                            else
                            begin
                                low_top_next = '0;
                            end
                        end
                        dss_pkg::CMD_SEARCH:
                        begin
                            key_next      = value;
                            high_sel_next = which_stack;
                            if (n_sel == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = dss_pkg::STAT_MISS;
                            end
                            else
                            begin
                                cmp_idx_next = top_idx;
                                rem_next     = n_sel;
                                state_next   = dss_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            dss_pkg::S_READ:
            begin
                fin       = 1'b1;
                fin_value = rd_data;
            end
            dss_pkg::S_SCAN:
            begin
                // The word for cmp_idx_reg arrives now; the next one is fetched meanwhile.
                rd_addr = ADDR_W'(step_idx);
                if (rd_data == key_reg)
                begin
                    fin      = 1'b1;
                    fin_midx = cmp_idx_reg[dss_pkg::IDX_W-1:0];
                end
                else if (rem_reg == 9'd1)
                begin
                    fin        = 1'b1;
                    fin_status = dss_pkg::STAT_MISS;
                end
                else
                begin
                    cmp_idx_next = step_idx;
                    rem_next     = rem_reg - 1'b1;
                end
            end
            dss_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = dss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dss_pkg::S_IDLE;
            end
        endcase

        // A capacity write moves the high stack's base, so both stacks restart.
        if (cfg_clear)
        begin
            low_top_next    = '0;
            high_count_next = '0;
        end

        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_midx_next   = res_midx_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_midx_next   = out_midx_reg;
        load            = 1'b0;

        if (state_reg == dss_pkg::S_HOLD)
        begin
            if (out_free)
            begin
                load            = 1'b1;
                out_status_next = res_status_reg;
                out_value_next  = res_value_reg;
                out_midx_next   = res_midx_reg;
            end
        end
        else if (fin)
        begin
            if (out_free)
            begin
                load            = 1'b1;
                out_status_next = fin_status;
                out_value_next  = fin_value;
                out_midx_next   = fin_midx;
                state_next      = dss_pkg::S_IDLE;
            end
            else
            begin
                res_status_next = fin_status;
                res_value_next  = fin_value;
                res_midx_next   = fin_midx;
                state_next      = dss_pkg::S_HOLD;
            end
        end

        sum_next = {1'b0, low_top_next} + {1'b0, high_count_next};

        if (load)
        begin
            out_valid_next = 1'b1;
            out_low_next   = low_top_next;
            out_high_next  = high_count_next;
            out_full_next  = (sum_next >= {1'b0, cap_eff});
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            out_low_next   = out_low_reg;
            out_high_next  = out_high_reg;
            out_full_next  = out_full_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign read_value      = out_value_reg;
    assign match_index     = out_midx_reg;
    assign size_low_stack  = out_low_reg;
    assign size_high_stack = out_high_reg;
    assign is_full         = out_full_reg;

    // The two stacks never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        sum_now <= {1'b0, cap_eff})
        else $error("stack pointers overlap");

    // A search walk always has at least one entry left to compare.
    a_scan_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dss_pkg::S_SCAN) |-> (rem_reg != '0))
        else $error("search walk with no entries left");

    // A push into a store with room grows the total by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command == dss_pkg::CMD_PUSH) && !full_now && !cfg_clear)
        |=> (sum_now == $past(sum_now) + 1'b1))
        else $error("push did not grow the stacks by one");

    // A pop or peek on a non-empty stack waits in S_READ for the store read.
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((command == dss_pkg::CMD_POP) || (command == dss_pkg::CMD_PEEK))
         && (n_sel != '0))
        |=> (state_reg == dss_pkg::S_READ) || (state_reg == dss_pkg::S_IDLE))
        else $error("pop or peek skipped the store read");

endmodule

`default_nettype wire

// ===== rtl/dual_stack_shared_store_top.sv =====
// ============================================================================
// dual_stack_shared_store_top
// Two stacks in one shared word store: capacity register, store and sequencer.
// ============================================================================
// Push, clear, no-op and refused commands: result loaded into the output register
//   from S_IDLE, so the next item can follow unless the output stalls (S_HOLD).
// Pop and peek: pass through S_READ for the registered read of the store.
// Search: walks down from the top in S_SCAN until a hit or until all size entries
//   are compared, one store read per cycle through the sequencer's compare.
// Reset: both stacks empty, capacity 256 (limited to DEPTH), store undefined.
`default_nettype none

module dual_stack_shared_store_top #(
    parameter int DEPTH = dss_pkg::DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [dss_pkg::CNT_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [dss_pkg::CMD_W-1:0]        command,
    input  wire logic                             which_stack,
    input  wire logic signed [dss_pkg::DATA_W-1:0] value,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [dss_pkg::STAT_W-1:0]            status,
    output logic signed [dss_pkg::DATA_W-1:0]     read_value,
    output logic [dss_pkg::IDX_W-1:0]             match_index,
    output logic [dss_pkg::CNT_W-1:0]             size_low_stack,
    output logic [dss_pkg::CNT_W-1:0]             size_high_stack,
    output logic                                  is_full
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [dss_pkg::CNT_W-1:0]  capacity_reg, capacity_next;
    logic [dss_pkg::CNT_W-1:0]  cap_eff;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [dss_pkg::DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic [dss_pkg::DATA_W-1:0] rd_data;
    logic [dss_pkg::DATA_W-1:0] read_word;

    assign capacity_next = cfg_write ? cfg_data : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= dss_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Zero acts as one entry and anything beyond the store acts as the whole store.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = 9'd1;
        end
        else if (32'(capacity_reg) > DEPTH)
        begin
            cap_eff = dss_pkg::CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    dss_ram #(
        .WIDTH (dss_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dss_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cap_eff         (cap_eff),
        .cfg_clear       (cfg_write),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .which_stack     (which_stack),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .read_value      (read_word),
        .match_index     (match_index),
        .size_low_stack  (size_low_stack),
        .size_high_stack (size_high_stack),
        .is_full         (is_full),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data)
    );

    assign read_value = signed'(read_word);

endmodule

`default_nettype wire
